### src/hvt_pkg.sv
// Shared constants and types for the homogeneous vertex transform unit.
package hvt_pkg;

	localparam int FRAC_BITS_DEF = 8;
	localparam int WORD_BITS_DEF = 32;
	localparam int DATA_W        = 32;
	localparam int IDX_W         = 4;
	localparam int DIM           = 4;
	localparam int NENT          = DIM * DIM;
	localparam int NLANE         = 3;

	typedef enum logic {
		ACT_LOAD  = 1'b0,
		ACT_XFORM = 1'b1
	} hvt_action_t;

	// Sideband that rides with each vertex through the divide pipeline
	typedef struct packed {
		logic             vld;
		logic             wzero;
		logic             bypass;
		logic [NLANE-1:0] neg;
	} hvt_ctl_t;

endpackage

### src/hvt_in_if.sv
// Input channel: matrix loads and vertices.
interface hvt_in_if
	import hvt_pkg::*;
	;
	logic                     valid;
	logic                     ready;
	logic                     action;
	logic [IDX_W-1:0]         entry_index;
	logic signed [DATA_W-1:0] entry_value;
	logic signed [DATA_W-1:0] vec_x;
	logic signed [DATA_W-1:0] vec_y;
	logic signed [DATA_W-1:0] vec_z;

	modport source (output valid, action, entry_index, entry_value, vec_x, vec_y, vec_z,
		input ready);
	modport sink (input valid, action, entry_index, entry_value, vec_x, vec_y, vec_z,
		output ready);
endinterface

### src/hvt_out_if.sv
// Output channel: transformed vertices.
interface hvt_out_if
	import hvt_pkg::*;
	;
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] out_x;
	logic signed [DATA_W-1:0] out_y;
	logic signed [DATA_W-1:0] out_z;
	logic                     w_zero;

	modport source (output valid, out_x, out_y, out_z, w_zero, input ready);
	modport sink (input valid, out_x, out_y, out_z, w_zero, output ready);
endinterface

### src/hvt_mat_pipe.sv
// Matrix store and the multiply / row-sum pipeline (three stages).
module hvt_mat_pipe
	import hvt_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        ld,
	input  logic                        xf,
	input  logic [IDX_W-1:0]            entry_index,
	input  logic signed [DATA_W-1:0]    entry_value,
	input  logic signed [DATA_W-1:0]    vec_x,
	input  logic signed [DATA_W-1:0]    vec_y,
	input  logic signed [DATA_W-1:0]    vec_z,
	output logic                        sum_vld,
	output logic signed [WORD_BITS-1:0] sum [DIM]
);

	localparam logic [DATA_W-1:0] ONE_ENT = DATA_W'(64'(1) << FRAC_BITS);

	logic [DATA_W-1:0]          mat_q [NENT];
	logic signed [DATA_W-1:0]   vec [NLANE];
	logic signed [WORD_BITS-1:0] prod_s1 [DIM][NLANE];
	logic signed [WORD_BITS-1:0] trans_s1 [DIM];
	logic signed [WORD_BITS-1:0] pa_s2 [DIM];
	logic signed [WORD_BITS-1:0] pb_s2 [DIM];
	logic signed [WORD_BITS-1:0] sum_s3 [DIM];
	logic v_s1, v_s2, v_s3;

	assign vec[0] = vec_x;
	assign vec[1] = vec_y;
	assign vec[2] = vec_z;

	// Matrix store, identity after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NENT; i++) begin
				mat_q[i] <= (i % (DIM + 1) == 0) ? ONE_ENT : '0;
			end
		end else if (ld) begin
			mat_q[entry_index] <= entry_value;
		end
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= xf;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1: scaled products and translation terms
	for (genvar r = 0; r < DIM; r++) begin : g_row
		logic signed [63:0] tr_ext;
		assign tr_ext = 64'($signed(mat_q[r*DIM+3]));

		for (genvar c = 0; c < NLANE; c++) begin : g_col
			logic signed [63:0] prod;
			logic signed [63:0] prod_sh;
			assign prod    = vec[c] * $signed(mat_q[r*DIM+c]);
			assign prod_sh = prod >>> FRAC_BITS;
			always_ff @(posedge clk) begin
				if (en) prod_s1[r][c] <= prod_sh[WORD_BITS-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				trans_s1[r] <= tr_ext[WORD_BITS-1:0];
				// Stage 2: pairwise sums
				pa_s2[r]    <= prod_s1[r][0] + prod_s1[r][1];
				pb_s2[r]    <= prod_s1[r][2] + trans_s1[r];
				// Stage 3: row sum
				sum_s3[r]   <= pa_s2[r] + pb_s2[r];
			end
		end
		assign sum[r] = sum_s3[r];
	end

	assign sum_vld = v_s3;

endmodule

### src/hvt_div_pipe.sv
// Perspective divide: prep stage, one quotient bit per stage, result select.
module hvt_div_pipe
	import hvt_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        sum_vld,
	input  logic signed [WORD_BITS-1:0] sum [DIM],
	output logic                        res_vld,
	output logic                        res_wzero,
	output logic [DATA_W-1:0]           res_val [NLANE]
);

	localparam int NSTEP = WORD_BITS + FRAC_BITS;
	localparam logic [63:0] ONE64 = 64'(1) << FRAC_BITS;
	localparam logic [WORD_BITS-1:0] ONE_W = ONE64[WORD_BITS-1:0];

	hvt_ctl_t               ctl_s [NSTEP+1];
	logic [WORD_BITS-1:0]   den_s [NSTEP+1];
	logic [WORD_BITS-1:0]   rem_s [NSTEP+1][NLANE];
	logic [NSTEP-1:0]       dvd_s [NSTEP+1][NLANE];
	logic [WORD_BITS-1:0]   quo_s [NSTEP+1][NLANE];
	logic [WORD_BITS-1:0]   raw_s [NSTEP+1][NLANE];

	logic [WORD_BITS-1:0] w_raw;
	logic [WORD_BITS-1:0] w_abs;
	hvt_ctl_t             ctl_d;

	assign w_raw = sum[DIM-1];
	assign w_abs = w_raw[WORD_BITS-1] ? WORD_BITS'(-w_raw) : w_raw;

	// Prep stage: flags, signs and magnitudes
	always_comb begin
		ctl_d.vld    = sum_vld;
		ctl_d.wzero  = (w_raw == '0);
		ctl_d.bypass = (w_raw != '0) && (w_raw == ONE_W);
		for (int l = 0; l < NLANE; l++) begin
			ctl_d.neg[l] = sum[l][WORD_BITS-1] ^ w_raw[WORD_BITS-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctl_s[0] <= '0;
		else if (en) ctl_s[0] <= ctl_d;
	end

	always_ff @(posedge clk) begin
		if (en) den_s[0] <= w_abs;
	end

	for (genvar l = 0; l < NLANE; l++) begin : g_prep
		logic [WORD_BITS-1:0] n_abs;
		assign n_abs = sum[l][WORD_BITS-1] ? WORD_BITS'(-sum[l]) : sum[l];
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[0][l] <= '0;
				dvd_s[0][l] <= NSTEP'(n_abs) << FRAC_BITS;
				quo_s[0][l] <= '0;
				raw_s[0][l] <= sum[l];
			end
		end
	end

	// Restoring divide, one quotient bit per stage
	for (genvar k = 1; k <= NSTEP; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) ctl_s[k] <= '0;
			else if (en) ctl_s[k] <= ctl_s[k-1];
		end
		always_ff @(posedge clk) begin
			if (en) den_s[k] <= den_s[k-1];
		end

		for (genvar l = 0; l < NLANE; l++) begin : g_lane
			logic [WORD_BITS:0]   trial;
			logic [WORD_BITS:0]   diff;
			logic                 ge;
			assign trial = {rem_s[k-1][l], dvd_s[k-1][l][NSTEP-1]};
			assign diff  = trial - {1'b0, den_s[k-1]};
			assign ge    = (trial >= {1'b0, den_s[k-1]});
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k][l] <= ge ? diff[WORD_BITS-1:0] : trial[WORD_BITS-1:0];
					dvd_s[k][l] <= dvd_s[k-1][l] << 1;
					quo_s[k][l] <= {quo_s[k-1][l][WORD_BITS-2:0], ge};
					raw_s[k][l] <= raw_s[k-1][l];
				end
			end
		end
	end

	// Sign fix and result select
	for (genvar l = 0; l < NLANE; l++) begin : g_sel
		logic [WORD_BITS-1:0] q_fix;
		logic [WORD_BITS-1:0] v_sel;
		logic signed [63:0]   v_ext;
		always_comb begin
			q_fix = ctl_s[NSTEP].neg[l] ? WORD_BITS'(-quo_s[NSTEP][l]) : quo_s[NSTEP][l];
			if (ctl_s[NSTEP].wzero)       v_sel = '0;
			else if (ctl_s[NSTEP].bypass) v_sel = raw_s[NSTEP][l];
			else                          v_sel = q_fix;
		end
		assign v_ext      = 64'($signed(v_sel));
		assign res_val[l] = v_ext[DATA_W-1:0];
	end

	assign res_vld   = ctl_s[NSTEP].vld;
	assign res_wzero = ctl_s[NSTEP].wzero;

	// w cannot be both zero and one on its way out
	a_flags_excl: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s[NSTEP].vld |-> !(ctl_s[NSTEP].wzero && ctl_s[NSTEP].bypass))
		else $error("w flagged both zero and one");

endmodule

### src/homogeneous_vertex_transform_unit.sv
// Top level of the homogeneous 4x4 vertex transform unit.
// Usage:
//  vtx channel: each beat either loads one matrix entry (action 0, entry_index row-major,
//  entry_value fixed point) or transforms a vertex (action 1, vec_x/y/z fixed point).
//  res channel: one beat per vertex with out_x/y/z and w_zero; loads give no beat.
//  A load takes effect at its accept edge, so a vertex in the next cycle already sees it.
//  Throughput: one beat per cycle on vtx, vertices and loads alike, while vtx.ready is high.
//  Path: a vertex passes three multiply/sum stages, one prep stage, one stage per quotient
//  bit of the restoring divider, and the output register before res can take it.
//  The divide path is always taken; when w is one or zero its result is replaced
//  by the row sums or by zeros, so latency does not depend on the data.
//  Reset: the matrix returns to identity, all pipeline valid bits clear, res.valid drops.
//  Stall: while res.ready is low a held result stays on res and one more result is
//  parked in a skid register; only with the skid register full does vtx.ready drop and
//  the whole pipeline freeze. vtx.ready never depends on res.ready in the same cycle.
module homogeneous_vertex_transform_unit
	import hvt_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	hvt_in_if.sink   vtx,
	hvt_out_if.source res
);

	logic en, accept, ld, xf;
	logic sum_vld;
	logic signed [WORD_BITS-1:0] sum [DIM];
	logic res_vld, res_wzero;
	logic [DATA_W-1:0] res_val [NLANE];

	logic              ov_q, sv_q;
	logic [DATA_W-1:0] o_val_q [NLANE];
	logic [DATA_W-1:0] s_val_q [NLANE];
	logic              o_wz_q, s_wz_q;

	// Pipeline moves whenever the skid register is free
	assign en        = !sv_q;
	assign vtx.ready = en;
	assign accept    = vtx.valid && en;
	assign ld        = accept && (vtx.action == ACT_LOAD);
	assign xf        = accept && (vtx.action == ACT_XFORM);

	hvt_mat_pipe #(
		.FRAC_BITS(FRAC_BITS),
		.WORD_BITS(WORD_BITS)
	) u_mat (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.ld          (ld),
		.xf          (xf),
		.entry_index (vtx.entry_index),
		.entry_value (vtx.entry_value),
		.vec_x       (vtx.vec_x),
		.vec_y       (vtx.vec_y),
		.vec_z       (vtx.vec_z),
		.sum_vld     (sum_vld),
		.sum         (sum)
	);

	hvt_div_pipe #(
		.FRAC_BITS(FRAC_BITS),
		.WORD_BITS(WORD_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.sum_vld   (sum_vld),
		.sum       (sum),
		.res_vld   (res_vld),
		.res_wzero (res_wzero),
		.res_val   (res_val)
	);

	// Output register and skid register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
			sv_q <= 1'b0;
		end else if (sv_q) begin
			if (res.ready) sv_q <= 1'b0;
		end else if (res_vld) begin
			if (!ov_q || res.ready) ov_q <= 1'b1;
			else                    sv_q <= 1'b1;
		end else if (res.ready) begin
			ov_q <= 1'b0;
		end
	end

	// Output and skid payload
	always_ff @(posedge clk) begin
		if (sv_q) begin
			if (res.ready) begin
				o_val_q <= s_val_q;
				o_wz_q  <= s_wz_q;
			end
		end else if (res_vld) begin
			if (!ov_q || res.ready) begin
				o_val_q <= res_val;
				o_wz_q  <= res_wzero;
			end else begin
				s_val_q <= res_val;
				s_wz_q  <= res_wzero;
			end
		end
	end

	assign res.valid  = ov_q;
	assign res.out_x  = o_val_q[0];
	assign res.out_y  = o_val_q[1];
	assign res.out_z  = o_val_q[2];
	assign res.w_zero = o_wz_q;

	// Skid register only fills behind a held output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sv_q |-> ov_q)
		else $error("skid register full with output register empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sv_q) |-> $past(ov_q && !res.ready))
		else $error("skid register filled without a stalled output beat");

	a_wzero_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.w_zero) |-> (res.out_x == '0 && res.out_y == '0 && res.out_z == '0))
		else $error("zero w beat carries nonzero coordinates");

endmodule

### tb/sv/tb.sv
// Testbench for the homogeneous vertex transform unit: directed and random beats, self-checking.
`timescale 1ns / 1ps

module tb
	import hvt_pkg::*;
	;

	localparam int FRAC      = FRAC_BITS_DEF;
	localparam int ONE       = 1 << FRAC;
	localparam int LATENCY   = 5 + WORD_BITS_DEF + FRAC_BITS_DEF;
	localparam int CYCLE_CAP = 400000;

	typedef struct packed {
		logic signed [DATA_W-1:0] x;
		logic signed [DATA_W-1:0] y;
		logic signed [DATA_W-1:0] z;
		logic                     wz;
	} vertex_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	hvt_in_if  vtx ();
	hvt_out_if res ();

	homogeneous_vertex_transform_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.vtx    (vtx),
		.res    (res)
	);

	always #5 clk = ~clk;

	// shadow copy of the matrix and the queue of predicted vertices
	logic signed [DATA_W-1:0] shadow_mtx [NENT];
	vertex_out_t              pending_vertices [$];

	int errors      = 0;
	int vertices_ok = 0;
	int loads_seen  = 0;
	int cycles      = 0;
	int send_idle   = 0;
	int recv_stall  = 0;
	int hold_left   = 0;

	initial begin
		vtx.valid       = 1'b0;
		vtx.action      = ACT_LOAD;
		vtx.entry_index = '0;
		vtx.entry_value = '0;
		vtx.vec_x       = '0;
		vtx.vec_y       = '0;
		vtx.vec_z       = '0;
		res.ready       = 1'b0;
		for (int i = 0; i < NENT; i++)
			shadow_mtx[i] = (i % 5 == 0) ? ONE : 0;
	end

	// fixed-point product: full width, floor shift, wrap to the word
	function automatic logic signed [DATA_W-1:0] fx_mul(logic signed [DATA_W-1:0] a,
		logic signed [DATA_W-1:0] b);
		logic signed [63:0] wa;
		logic signed [63:0] wb;
		logic signed [63:0] p;
		wa = a;
		wb = b;
		p  = (wa * wb) >>> FRAC;
		return p[DATA_W-1:0];
	endfunction

	// scaled divide, truncated toward zero, wrapped to the word
	function automatic logic signed [DATA_W-1:0] fx_div(logic signed [DATA_W-1:0] num,
		logic signed [DATA_W-1:0] den);
		logic signed [63:0] sn;
		logic signed [63:0] sd;
		logic [63:0] n;
		logic [63:0] d;
		logic [63:0] q;
		sn = num;
		sd = den;
		n  = (sn < 0) ? -sn : sn;
		d  = (sd < 0) ? -sd : sd;
		q  = (n << FRAC) / d;
		if ((sn < 0) != (sd < 0))
			q = -q;
		return q[DATA_W-1:0];
	endfunction

	function automatic logic signed [DATA_W-1:0] row_dot(int r, logic signed [DATA_W-1:0] x,
		logic signed [DATA_W-1:0] y, logic signed [DATA_W-1:0] z);
		logic signed [DATA_W-1:0] s;
		s = fx_mul(x, shadow_mtx[4*r]);
		s = s + fx_mul(y, shadow_mtx[4*r+1]);
		s = s + fx_mul(z, shadow_mtx[4*r+2]);
		s = s + shadow_mtx[4*r+3];
		return s;
	endfunction

	function automatic vertex_out_t transform_vertex(logic signed [DATA_W-1:0] x,
		logic signed [DATA_W-1:0] y, logic signed [DATA_W-1:0] z);
		vertex_out_t o;
		logic signed [DATA_W-1:0] w;
		o.x = row_dot(0, x, y, z);
		o.y = row_dot(1, x, y, z);
		o.z = row_dot(2, x, y, z);
		w   = row_dot(3, x, y, z);
		o.wz = 1'b0;
		if (w == 0) begin
			o = '0;
			o.wz = 1'b1;
		end else if (w != ONE) begin
			o.x = fx_div(o.x, w);
			o.y = fx_div(o.y, w);
			o.z = fx_div(o.z, w);
		end
		return o;
	endfunction

	task automatic report_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
		$display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// input monitor predicts; output monitor checks against the oldest prediction
	always @(posedge clk) begin
		vertex_out_t e;
		cycles <= cycles + 1;
		if (arst_n && vtx.valid && vtx.ready) begin
			if (vtx.action == ACT_LOAD) begin
				shadow_mtx[vtx.entry_index] = vtx.entry_value;
				loads_seen++;
			end else
				pending_vertices.push_back(transform_vertex(vtx.vec_x, vtx.vec_y, vtx.vec_z));
		end
		if (arst_n && res.valid && res.ready) begin
			if (pending_vertices.size() == 0) begin
				$display("unexpected result beat at cycle %0d", cycles);
				errors++;
			end else begin
				e = pending_vertices.pop_front();
				if (res.out_x !== e.x) report_mismatch("out_x", res.out_x, e.x);
				if (res.out_y !== e.y) report_mismatch("out_y", res.out_y, e.y);
				if (res.out_z !== e.z) report_mismatch("out_z", res.out_z, e.z);
				if (res.w_zero !== e.wz)
					report_mismatch("w_zero", DATA_W'(res.w_zero), DATA_W'(e.wz));
				vertices_ok++;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (cycles > CYCLE_CAP) begin
			$display("timeout at cycle %0d", cycles);
			$display("status: fail");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			res.ready <= 1'b0;
		end else
			res.ready <= ($urandom_range(99) >= recv_stall);
	end

	// one beat on the input channel, with a random gap in front
	task automatic send_beat(hvt_action_t act, logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val,
		logic [DATA_W-1:0] x, logic [DATA_W-1:0] y, logic [DATA_W-1:0] z);
		while ($urandom_range(99) < send_idle) begin
			vtx.valid <= 1'b0;
			@(posedge clk);
		end
		vtx.valid       <= 1'b1;
		vtx.action      <= act;
		vtx.entry_index <= idx;
		vtx.entry_value <= val;
		vtx.vec_x       <= x;
		vtx.vec_y       <= y;
		vtx.vec_z       <= z;
		do @(posedge clk); while (!vtx.ready);
	endtask

	task automatic load_entry(int idx, logic [DATA_W-1:0] val);
		send_beat(ACT_LOAD, IDX_W'(idx), val, $urandom, $urandom, $urandom);
	endtask

	task automatic send_vertex(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y, logic [DATA_W-1:0] z);
		send_beat(ACT_XFORM, IDX_W'($urandom), $urandom, x, y, z);
	endtask

	task automatic wait_drained();
		vtx.valid <= 1'b0;
		while (pending_vertices.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic load_identity();
		for (int i = 0; i < NENT; i++)
			load_entry(i, (i % 5 == 0) ? ONE : 0);
	endtask

	// vertices through the reset identity: w is one, extremes pass straight through
	task automatic test_identity_extremes();
		send_vertex(32'h7fffffff, 32'h80000000, 32'h00000000);
		send_vertex(32'hffffffff, 32'h00000001, 32'h7fffffff);
		send_vertex(32'h80000000, 32'h7fffffff, 32'hffffffff);
		wait_drained();
	endtask

	// w of zero, a real divide, and extreme matrix entries with wrapping
	task automatic test_special_w();
		load_entry(15, 0);
		send_vertex(32'h00000300, 32'hfffffd00, 32'h00001000);
		load_entry(15, 2 * ONE);
		send_vertex(32'h00000300, 32'hfffffd00, 32'h00001000);
		load_entry(15, 32'h80000000);
		load_entry(0, 32'h7fffffff);
		load_entry(3, 32'h80000000);
		send_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff);
		load_entry(12, 32'hffffff00);
		load_entry(15, 32'h7fffffff);
		send_vertex(32'h80000000, 32'h00000001, 32'hffffffff);
		wait_drained();
		load_identity();
		wait_drained();
	endtask

	function automatic logic [DATA_W-1:0] rand_coord();
		case ($urandom_range(3))
			0:       return $urandom;
			1:       return $urandom_range(1, 0) ? 32'h7fffffff : 32'h80000000;
			default: return $signed($urandom_range(8191)) - 4096;
		endcase
	endfunction

	// random mix of loads and vertices under one setting of input idling and output stalls
	task automatic test_random_phase(int n, int idle_pct, int stall_pct);
		int r;
		send_idle  = idle_pct;
		recv_stall = stall_pct;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 5)
				load_entry(15, $urandom_range(1, 0) ? ONE : 0);
			else if (r < 25)
				load_entry($urandom_range(15), $urandom_range(1, 0) ? $urandom
					: $signed($urandom_range(1023)) - 512);
			else
				send_vertex(rand_coord(), rand_coord(), rand_coord());
		end
		wait_drained();
		send_idle  = 0;
		recv_stall = 0;
	endtask

	// receiver holds off a long while so the block fills and stalls its input
	task automatic test_backpressure();
		@(negedge clk);
		hold_left = 300;
		for (int i = 0; i < 120; i++)
			send_vertex(rand_coord(), rand_coord(), rand_coord());
		wait_drained();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_identity_extremes();
		test_special_w();
		test_random_phase(125, 0, 0);
		test_random_phase(125, 51, 0);
		test_random_phase(125, 0, 51);
		test_random_phase(125, 9, 9);
		test_backpressure();
		test_random_phase(100, 0, 0);
		$display("covered %0d matrix loads and %0d vertices checked", loads_seen, vertices_ok);
		$display("w one, w zero, divide, wrap and a long output stall included");
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
